@@ sv/rblf_pkg.sv @@
// ----------------------------------------------------------------------------
// rblf_pkg
// Shared constants, types and helpers for the row border line fit block.
// ----------------------------------------------------------------------------
package rblf_pkg;

  localparam int unsigned ROW_W   = 6;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned DIST_W  = 4;
  localparam int unsigned SLOPE_W = 11;
  localparam int unsigned OFF_W   = 17;
  localparam int unsigned TREND_W = 8;

  localparam int unsigned COLUMNS     = 128;
  localparam int unsigned WINDOW_SPAN = 4;
  localparam int unsigned HIST_DEPTH  = 8;   // max trend distance
  localparam int unsigned TAP_W       = 3;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic [DIST_W-1:0] MAX_TREND_DIST  = 4'd8;
  localparam logic [DIST_W-1:0] TREND_DIST_RST  = 4'd3;

  // Defaults for rows before the window is full, Q4
  localparam logic [OFF_W-1:0] RIGHT_OFF_DEFAULT = OFF_W'(16 * (COLUMNS - 1));
  localparam logic [OFF_W-1:0] MID_OFF_DEFAULT   = OFF_W'(16 * (COLUMNS / 2));

  // ceil(2^18 / 5): exact floor(n/5) for n below 2^18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIVD
  } rblf_state_e;

  typedef struct packed {
    logic load;   // capture item, form sums, shift history
    logic mult;   // form numerators and magnitudes
    logic div;    // scale by 1/5, load output register
  } rblf_cmd_t;

  function automatic logic [16:0] div5(input logic [18:0] mag);
    logic [34:0] prod;
    prod = 35'(mag) * 35'(DIV5_RECIP);
    return prod[34:DIV5_SHIFT];
  endfunction

endpackage

@@ sv/rblf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rblf_ctrl
// Sequencer: accept one row, step it through the product and divide stages,
// and hold the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rblf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rblf_pkg::rblf_cmd_t cmd_o
);

  rblf_pkg::rblf_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rblf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rblf_pkg::ST_MULT;
      end
      rblf_pkg::ST_MULT: begin
        state_d = rblf_pkg::ST_DIVD;
      end
      rblf_pkg::ST_DIVD: begin
        if (out_free) state_d = rblf_pkg::ST_IDLE;
      end
      default: begin
        state_d = rblf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rblf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rblf_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
      end
      rblf_pkg::ST_DIVD: begin
        cmd_o.div = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    // drop valid once taken, raise it when a new result lands
    out_valid_d = cmd_o.div || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rblf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/rblf_dp.sv @@
// ----------------------------------------------------------------------------
// rblf_dp
// Datapath: column history, window sums, products, divide by five by
// reciprocal multiply, trends and the output register.
// ----------------------------------------------------------------------------
module rblf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rblf_pkg::rblf_cmd_t                  cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [rblf_pkg::DIST_W-1:0]          cfg_wdata_i,
  input  logic [rblf_pkg::IN_TDATA_W-1:0]      in_data_i,
  output logic [rblf_pkg::OUT_TDATA_W-1:0]     out_data_o
);

  localparam int unsigned NL = 3;  // left, right, middle

  logic [rblf_pkg::DIST_W-1:0] tdist_q;

  logic [rblf_pkg::ROW_W-1:0] row_in;
  logic [rblf_pkg::COL_W-1:0] cur [NL];

  logic [rblf_pkg::COL_W-1:0] lhist_q [rblf_pkg::HIST_DEPTH];
  logic [rblf_pkg::COL_W-1:0] rhist_q [rblf_pkg::HIST_DEPTH];
  logic [rblf_pkg::COL_W-1:0] mhist_q [rblf_pkg::WINDOW_SPAN];
  logic [rblf_pkg::COL_W-1:0] win [NL][rblf_pkg::WINDOW_SPAN];

  // load stage
  logic [9:0]        x_d [NL];
  logic signed [9:0] s_d [NL];
  logic [9:0]        x_q [NL];
  logic signed [9:0] s_q [NL];
  logic [rblf_pkg::ROW_W-1:0] row_q;
  logic                       early_q;
  logic [rblf_pkg::DIST_W-1:0] dist_lim;
  logic [rblf_pkg::TAP_W-1:0]  tap;
  logic                        trend_en;
  logic [rblf_pkg::TREND_W-1:0] lt_d, rt_d, lt_q, rt_q;

  // product stage
  logic signed [6:0]  m_s;
  logic signed [16:0] ms [NL];
  logic signed [16:0] num [NL];
  logic [19:0]        num8 [NL];
  logic [19:0]        onum_mag [NL];
  logic [12:0]        snum8 [NL];
  logic [12:0]        snum_mag [NL];
  logic [18:0]        omag_q [NL];
  logic               oneg_q [NL];
  logic [11:0]        smag_q [NL];
  logic               sneg_q [NL];

  // divide stage
  logic [16:0]                  q_off [NL];
  logic [16:0]                  q_sl [NL];
  logic [rblf_pkg::OFF_W-1:0]   off_res [NL];
  logic [rblf_pkg::SLOPE_W-1:0] sl_res [NL];
  logic [rblf_pkg::OUT_TDATA_W-1:0] out_d, out_q;

  assign row_in = in_data_i[5:0];
  assign cur[0] = in_data_i[12:6];
  assign cur[1] = in_data_i[19:13];
  assign cur[2] = in_data_i[26:20];

  always_comb begin
    for (int k = 0; k < rblf_pkg::WINDOW_SPAN; k++) begin
      win[0][k] = lhist_q[k];
      win[1][k] = rhist_q[k];
      win[2][k] = mhist_q[k];
    end
  end

  // X = sum of five columns, S = 2*c0 + c1 - c3 - 2*c4
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      x_d[i] = 10'(cur[i]) + 10'(win[i][0]) + 10'(win[i][1]) + 10'(win[i][2])
             + 10'(win[i][3]);
      s_d[i] = 10'({cur[i], 1'b0}) + 10'(win[i][0]) - 10'(win[i][2])
             - 10'({win[i][3], 1'b0});
    end
  end

  always_comb begin
    dist_lim = (tdist_q > rblf_pkg::MAX_TREND_DIST) ? rblf_pkg::MAX_TREND_DIST : tdist_q;
    tap      = rblf_pkg::TAP_W'(dist_lim - 4'd1);
    trend_en = (dist_lim != '0) && (rblf_pkg::ROW_W'(dist_lim) <= row_in);
    lt_d     = '0;
    rt_d     = '0;
    if (trend_en) begin
      lt_d = 8'({1'b0, cur[0]}) - 8'({1'b0, lhist_q[tap]});
      rt_d = 8'({1'b0, cur[1]}) - 8'({1'b0, rhist_q[tap]});
    end
  end

  // m = row - 2; only meaningful once the window is full
  assign m_s = signed'(7'({1'b0, row_q})) - 7'sd2;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ms[i]       = 17'(m_s) * 17'(s_q[i]);
      num[i]      = signed'(17'({x_q[i], 1'b0})) - ms[i];
      num8[i]     = {num[i], 3'b000};
      onum_mag[i] = num[i][16] ? 20'(20'd0 - num8[i]) : num8[i];
      snum8[i]    = {s_q[i], 3'b000};
      snum_mag[i] = s_q[i][9] ? 13'(13'd0 - snum8[i]) : snum8[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      q_off[i]   = rblf_pkg::div5(omag_q[i]);
      q_sl[i]    = rblf_pkg::div5(19'(smag_q[i]));
      off_res[i] = oneg_q[i] ? 17'(17'd0 - q_off[i]) : q_off[i];
      sl_res[i]  = sneg_q[i] ? 11'(11'd0 - q_sl[i][10:0]) : q_sl[i][10:0];
    end
    if (early_q) begin
      for (int i = 0; i < NL; i++) sl_res[i] = '0;
      off_res[0] = '0;
      off_res[1] = rblf_pkg::RIGHT_OFF_DEFAULT;
      off_res[2] = rblf_pkg::MID_OFF_DEFAULT;
    end
    out_d = {6'b000000, rt_q, lt_q,
             off_res[2], sl_res[2], off_res[1], sl_res[1],
             off_res[0], sl_res[0], row_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tdist_q <= rblf_pkg::TREND_DIST_RST;
      for (int k = 0; k < rblf_pkg::HIST_DEPTH; k++) begin
        lhist_q[k] <= '0;
        rhist_q[k] <= '0;
      end
      for (int k = 0; k < rblf_pkg::WINDOW_SPAN; k++) mhist_q[k] <= '0;
    end else begin
      if (cfg_we_i) tdist_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        // advance history, newest row at entry 0
        for (int k = rblf_pkg::HIST_DEPTH - 1; k > 0; k--) begin
          lhist_q[k] <= lhist_q[k-1];
          rhist_q[k] <= rhist_q[k-1];
        end
        for (int k = rblf_pkg::WINDOW_SPAN - 1; k > 0; k--) mhist_q[k] <= mhist_q[k-1];
        lhist_q[0] <= cur[0];
        rhist_q[0] <= cur[1];
        mhist_q[0] <= cur[2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q   <= row_in;
      early_q <= (row_in < rblf_pkg::ROW_W'(rblf_pkg::WINDOW_SPAN));
      lt_q    <= lt_d;
      rt_q    <= rt_d;
      for (int i = 0; i < NL; i++) begin
        x_q[i] <= x_d[i];
        s_q[i] <= s_d[i];
      end
    end
    if (cmd_i.mult) begin
      for (int i = 0; i < NL; i++) begin
        omag_q[i] <= onum_mag[i][18:0];
        oneg_q[i] <= num[i][16];
        smag_q[i] <= snum_mag[i][11:0];
        sneg_q[i] <= s_q[i][9];
      end
    end
    if (cmd_i.div) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

@@ sv/row_border_line_fit.sv @@
// ----------------------------------------------------------------------------
// row_border_line_fit
// Per-row least-squares line fits over five rows for left, right and middle
// lines, plus left and right column trends.
// ----------------------------------------------------------------------------
// An accepted item steps through capture, product and divide in that order
// before m_axis_tvalid rises; the capture,
// product and reciprocal divide stages are used by one item at a time.
// A result waiting in the output register stalls only the divide stage.
// Reset: trend distance 3, column history cleared to zero, no result valid.
// ----------------------------------------------------------------------------
module row_border_line_fit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rblf_pkg::DIST_W-1:0]         cfg_wdata_i,     // trend_distance
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row_index[5:0], left_col[12:6], right_col[19:13], mid_col[26:20], zero pad
  input  logic [rblf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_row[5:0], left_slope[16:6], left_offset[33:17], right_slope[44:34],
  // right_offset[61:45], mid_slope[72:62], mid_offset[89:73],
  // left_trend[97:90], right_trend[105:98], zero pad
  output logic [rblf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  rblf_pkg::rblf_cmd_t cmd;

  rblf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  rblf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  a_load_then_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.mult)
    else $error("product stage did not follow capture");

  a_div_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div |=> m_axis_tvalid)
    else $error("output register loaded without valid");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mult, cmd.div}))
    else $error("more than one stage command active");

endmodule
